// ===== rtl/sssp_pkg.sv =====
package sssp_pkg;

    // Angle in degrees as carried on the ports and held in state
    localparam int ANGLE_W = 7;
    // One extra bit so a step past the limits does not wrap
    localparam int EXT_W   = ANGLE_W + 1;
    localparam int CMP_W   = 16;
    localparam int CFG_W   = 7;

    // Mechanical angle range of the servo
    localparam int ANGLE_LIM   = 60;
    localparam int TABLE_DEPTH = 2 * ANGLE_LIM + 1;
    localparam int TABLE_AW    = $clog2(TABLE_DEPTH);

    // Pulse width scaling: compare = PERIOD * (CMP_OFFSET - angle) / CMP_DIV
    localparam int CMP_OFFSET = 2220;
    localparam int CMP_DIV    = 2400;

    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef logic signed [EXT_W-1:0]   angle_ext_t;

    // Tick commands
    localparam logic CMD_AUTO   = 1'b0;
    localparam logic CMD_MANUAL = 1'b1;

    // Configuration register indexes
    localparam logic REG_SWEEP_MIN = 1'b0;
    localparam logic REG_SWEEP_MAX = 1'b1;

    localparam angle_ext_t LIM_HI = angle_ext_t'(ANGLE_LIM);
    localparam angle_ext_t LIM_LO = angle_ext_t'(-ANGLE_LIM);

    function automatic angle_ext_t widen(input angle_t a);
        return angle_ext_t'(a);
    endfunction

    // Clamp a stepped angle back into the servo range
    function automatic angle_t clamp_angle(input angle_ext_t a);
        angle_ext_t r;
        if (a < LIM_LO)
        begin
            r = LIM_LO;
        end
        else if (a > LIM_HI)
        begin
            r = LIM_HI;
        end
        else
        begin
            r = a;
        end
        return r[ANGLE_W-1:0];
    endfunction

endpackage

// ===== rtl/servo_sweep_slew_pwm.sv =====
// Servo sweep and slew controller with a PWM compare output. Each accepted
// request is one servo update tick: an auto tick moves the sweep angle one
// degree between sweep_min and sweep_max and turns at the limits, a manual
// tick moves a tracking angle one degree toward target_deg (the tracking
// angle is loaded from the sweep angle on the first manual tick after reset
// or an auto tick). The result is the clamped angle and the compare value
// floor(PERIOD_COUNT*(2220-angle)/2400), read from a 121-entry constant
// table built from PERIOD_COUNT. One request is taken every cycle unless
// in_stall is high, which is only while the output register holds a
// result and out_stall is high; a result is there on the next cycle.
module servo_sweep_slew_pwm
    import sssp_pkg::*;
#(
    parameter int PERIOD_COUNT = 49999
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                command,
    input  logic signed [ANGLE_W-1:0] target_deg,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [CMP_W-1:0]    compare_value,
    output logic signed [ANGLE_W-1:0] angle_out
);

    angle_t            sweep_min_reg;
    angle_t            sweep_max_reg;
    angle_t            sweep_angle_reg;
    angle_t            sweep_angle_next;
    angle_t            manual_angle_reg;
    angle_t            manual_angle_next;
    logic              rising_reg;
    logic              rising_next;
    logic              was_manual_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CMP_W-1:0]  compare_reg;
    angle_t            angle_out_reg;
    angle_t            angle_new;
    logic              accept;
    logic              out_take;
    logic [CMP_W-1:0]  cmp_rom [TABLE_DEPTH];
    angle_ext_t        table_pos;

    // Build the compare table, one entry per degree from -60 upward
    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cmp_rom
        localparam int CMP_ENTRY =
            (PERIOD_COUNT * (CMP_OFFSET + ANGLE_LIM - g)) / CMP_DIV;
        assign cmp_rom[g] = CMP_W'(CMP_ENTRY);
    end

    // Handshake: hold the input while a result waits on a stalled output
    assign out_take = out_valid_reg && !out_stall;
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // Step the selected angle one degree, or hold a manual angle at its target
    always_comb
    begin
        angle_ext_t a;
        angle_ext_t lo;
        angle_ext_t hi;
        angle_ext_t tgt;
        angle_ext_t step;
        a    = widen(sweep_angle_reg);
        lo   = widen(sweep_min_reg);
        hi   = widen(sweep_max_reg);
        tgt  = widen(target_deg);
        step = a;
        sweep_angle_next  = sweep_angle_reg;
        manual_angle_next = manual_angle_reg;
        rising_next       = rising_reg;
        unique case (command)
            CMD_AUTO:
            begin
                priority if (a < lo)
                begin
                    step        = a + angle_ext_t'(1);
                    rising_next = 1'b1;
                end
                else if (a > hi)
                begin
                    step        = a - angle_ext_t'(1);
                    rising_next = 1'b0;
                end
                else if (rising_reg)
                begin
                    step = a + angle_ext_t'(1);
                    if (step >= hi)
                    begin
                        rising_next = 1'b0;
                    end
                end
                else
                begin
                    step = a - angle_ext_t'(1);
                    if (step <= lo)
                    begin
                        rising_next = 1'b1;
                    end
                end
                sweep_angle_next = clamp_angle(step);
                angle_new        = sweep_angle_next;
            end
            CMD_MANUAL:
            begin
                if (was_manual_reg)
                begin
                    a = widen(manual_angle_reg);
                end
                priority if (a < tgt)
                begin
                    step = a + angle_ext_t'(1);
                end
                else if (a > tgt)
                begin
                    step = a - angle_ext_t'(1);
                end
                else
                begin
                    step = a;
                end
                manual_angle_next = clamp_angle(step);
                angle_new         = manual_angle_next;
            end
            default:
            begin
                angle_new = sweep_angle_reg;
            end
        endcase
    end

    // Map the new angle onto a table row
    assign table_pos = widen(angle_new) + LIM_HI;

    // Drop the valid flag once taken unless a new request lands
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_min_reg <= angle_t'(-ANGLE_LIM);
            sweep_max_reg <= angle_t'(ANGLE_LIM);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SWEEP_MIN: sweep_min_reg <= cfg_data;
                REG_SWEEP_MAX: sweep_max_reg <= cfg_data;
                default:       sweep_min_reg <= sweep_min_reg;
            endcase
        end
    end

    // Advance angle state on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_angle_reg  <= '0;
            manual_angle_reg <= '0;
            rising_reg       <= 1'b1;
            was_manual_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                sweep_angle_reg  <= sweep_angle_next;
                manual_angle_reg <= manual_angle_next;
                rising_reg       <= rising_next;
                was_manual_reg   <= (command == CMD_MANUAL);
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            compare_reg   <= cmp_rom[table_pos[TABLE_AW-1:0]];
            angle_out_reg <= angle_new;
        end
    end

    assign out_valid     = out_valid_reg;
    assign compare_value = compare_reg;
    assign angle_out     = angle_out_reg;

endmodule

// ===== rtl/sssp_checker.sv =====
module sssp_checker
    import sssp_pkg::*;
#(
    parameter int PERIOD_COUNT = 49999
)
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [CMP_W-1:0]            compare_value,
    input logic signed [ANGLE_W-1:0]   angle_out
);

    // Stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(compare_value) && $stable(angle_out))
    else $error("stalled result changed");

    // Input side stalls only behind a held result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

    // Taken result with no new request leaves the output empty
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !(in_valid && !in_stall) |=> !out_valid)
    else $error("result repeated");

    // Angle stays in servo range and compare stays below the period
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> angle_out >= -7'sd60 && angle_out <= 7'sd60
                      && 32'(compare_value) < PERIOD_COUNT)
    else $error("result out of range");

endmodule

bind servo_sweep_slew_pwm sssp_checker #(.PERIOD_COUNT(PERIOD_COUNT)) u_sssp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .compare_value (compare_value),
    .angle_out     (angle_out)
);
